>>> src/contiguous_access_segment_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous access segment counter
// Shared helpers that wrap concurrent assertions on the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_ACCESS_SEGMENT_COUNTER_TOP_DEFINES_SVH
`define CONTIGUOUS_ACCESS_SEGMENT_COUNTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CASC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CASC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/casc_pkg.sv
// ----------------------------------------------------------------------------
// casc_pkg
// Widths, register indexes, types and the long division step shared by the
// contiguous access segment counter and its channel interfaces.
// ----------------------------------------------------------------------------
package casc_pkg;

	localparam int POS_W     = 31;
	localparam int LEN_W     = 16;
	localparam int WID_W     = 9;
	localparam int TR_W      = 2;
	localparam int PART_W    = 2;
	localparam int FULL_W    = 16;
	localparam int DVD_W     = 32;
	localparam int BPS       = 4;
	localparam int DIV_STAGES = DVD_W / BPS;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ACCESS_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b1;

	localparam logic [WID_W-1:0] WIDTH_RESET = 9'd32;

	typedef struct packed {
		logic zero_len;
		logic one_len;
		logic fits_seg;
		logic short_line;
	} len_flags_t;

	typedef struct packed {
		logic [WID_W-1:0] rem;
		logic [BPS-1:0]   quo;
	} chunk_t;

	// Restoring division over BPS dividend bits, most significant first.
	// The incoming remainder is always below the divisor.
	function automatic chunk_t div_chunk(
		input logic [WID_W-1:0] rem,
		input logic [BPS-1:0]   bits,
		input logic [WID_W-1:0] dvsr
	);
		logic [WID_W:0] r;
		chunk_t         res;
		r = {1'b0, rem};
		res = '0;
		for (int i = BPS - 1; i >= 0; i--) begin
			r = {r[WID_W-1:0], bits[i]};
			if (r >= {1'b0, dvsr}) begin
				r = r - {1'b0, dvsr};
				res.quo[i] = 1'b1;
			end else begin
				res.quo[i] = 1'b0;
			end
		end
		res.rem = r[WID_W-1:0];
		return res;
	endfunction

endpackage

>>> src/casc_req_if.sv
// ----------------------------------------------------------------------------
// casc_req_if
// Valid/ready channel that carries one contiguous access description.
// ----------------------------------------------------------------------------
interface casc_req_if;
	logic                        valid;
	logic                        ready;
	logic [casc_pkg::POS_W-1:0] start_pos;
	logic [casc_pkg::LEN_W-1:0] length;

	modport source (output valid, output start_pos, output length, input ready);
	modport sink   (input valid, input start_pos, input length, output ready);
endinterface

>>> src/casc_rsp_if.sv
// ----------------------------------------------------------------------------
// casc_rsp_if
// Valid/ready channel that carries the transaction and cache line counts.
// ----------------------------------------------------------------------------
interface casc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [casc_pkg::TR_W-1:0]   transactions;
	logic [casc_pkg::FULL_W-1:0] full_lines;
	logic [casc_pkg::PART_W-1:0] partial_lines;

	modport source (output valid, output transactions, output full_lines,
		output partial_lines, input ready);
	modport sink   (input valid, input transactions, input full_lines,
		input partial_lines, output ready);
endinterface

>>> src/contiguous_access_segment_counter_top.sv
// ----------------------------------------------------------------------------
// Contiguous access segment counter: an input stage, eight four-bit long division stages
// and an output register. A result goes from the input stage through the division stages
// to the output register, which offers it on the result channel.
// One access is taken every cycle; a stalled output holds the whole pipeline.
// Reset clears all stage valid bits and sets both width registers to 32.
// ----------------------------------------------------------------------------
`include "contiguous_access_segment_counter_top_defines.svh"

module contiguous_access_segment_counter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [casc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [casc_pkg::WID_W-1:0]      cfg_wdata,
	casc_req_if.sink                        request,
	casc_rsp_if.source                      result
);

	localparam int N = casc_pkg::DIV_STAGES;

	// Effective widths: a written zero is held as one.
	logic [casc_pkg::WID_W-1:0] access_width_q;
	logic [casc_pkg::WID_W-1:0] line_width_q;
	logic [casc_pkg::WID_W-1:0] cfg_eff;

	// Stage arrays: index 0 is the input stage, index k holds the state after
	// k division steps of four bits each.
	logic                          valid_s   [N+1];
	logic [casc_pkg::DVD_W-1:0]    pos_s     [N+1];
	logic [casc_pkg::DVD_W-1:0]    sum_s     [N+1];
	logic [casc_pkg::LEN_W-1:0]    len_s     [N+1];
	casc_pkg::len_flags_t          flags_s   [N+1];
	logic [casc_pkg::WID_W-1:0]    rem_a_s   [N+1];
	logic [casc_pkg::WID_W-1:0]    rem_b_s   [N+1];
	logic [casc_pkg::WID_W-1:0]    rem_c_s   [N+1];
	logic [casc_pkg::FULL_W-1:0]   quo_b_s   [N+1];
	logic [casc_pkg::FULL_W-1:0]   quo_c_s   [N+1];

	logic                          valid_s10;
	logic [casc_pkg::TR_W-1:0]     tr_s10;
	logic [casc_pkg::FULL_W-1:0]   full_s10;
	logic [casc_pkg::PART_W-1:0]   part_s10;

	logic                          adv;
	casc_pkg::len_flags_t          flags_in;
	logic [casc_pkg::TR_W-1:0]     tr_d;
	logic [casc_pkg::FULL_W-1:0]   full_d;
	logic [casc_pkg::PART_W-1:0]   part_d;

	// The whole pipeline moves together whenever the output register is free.
	assign adv = !valid_s10 || result.ready;
	assign request.ready = adv;

	assign cfg_eff = (cfg_wdata == '0) ? casc_pkg::WID_W'(1) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_width_q <= casc_pkg::WIDTH_RESET;
			line_width_q   <= casc_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				casc_pkg::REG_ACCESS_WIDTH: access_width_q <= cfg_eff;
				casc_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_eff;
				default: ;
			endcase
		end
	end

	always_comb begin
		flags_in.zero_len   = (request.length == '0);
		flags_in.one_len    = (request.length == casc_pkg::LEN_W'(1));
		flags_in.fits_seg   = (request.length <= {7'b0, access_width_q});
		flags_in.short_line = (request.length <  {7'b0, line_width_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s[0]   <= {1'b0, request.start_pos};
			sum_s[0]   <= {1'b0, request.start_pos} + {16'b0, request.length};
			len_s[0]   <= request.length;
			flags_s[0] <= flags_in;
			rem_a_s[0] <= '0;
			rem_b_s[0] <= '0;
			rem_c_s[0] <= '0;
			quo_b_s[0] <= '0;
			quo_c_s[0] <= '0;
		end
	end

	// Three division lanes: start position by segment width, start position
	// by line width, and the end position by line width. Only the low
	// quotient bits are kept, as the line count is their difference.
	for (genvar k = 1; k <= N; k++) begin : g_div
		localparam int MSB = casc_pkg::DVD_W - 1 - casc_pkg::BPS * (k - 1);
		casc_pkg::chunk_t step_a;
		casc_pkg::chunk_t step_b;
		casc_pkg::chunk_t step_c;

		assign step_a = casc_pkg::div_chunk(rem_a_s[k-1], pos_s[k-1][MSB -: casc_pkg::BPS],
			access_width_q);
		assign step_b = casc_pkg::div_chunk(rem_b_s[k-1], pos_s[k-1][MSB -: casc_pkg::BPS],
			line_width_q);
		assign step_c = casc_pkg::div_chunk(rem_c_s[k-1], sum_s[k-1][MSB -: casc_pkg::BPS],
			line_width_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pos_s[k]   <= pos_s[k-1];
				sum_s[k]   <= sum_s[k-1];
				len_s[k]   <= len_s[k-1];
				flags_s[k] <= flags_s[k-1];
				rem_a_s[k] <= step_a.rem;
				rem_b_s[k] <= step_b.rem;
				rem_c_s[k] <= step_c.rem;
				quo_b_s[k] <= {quo_b_s[k-1][casc_pkg::FULL_W-casc_pkg::BPS-1:0], step_b.quo};
				quo_c_s[k] <= {quo_c_s[k-1][casc_pkg::FULL_W-casc_pkg::BPS-1:0], step_c.quo};
			end
		end
	end

	always_comb begin
		logic                      head_nz;
		logic                      tail_nz;
		logic [casc_pkg::LEN_W:0]  seg_end;
		logic [casc_pkg::LEN_W:0]  line_end;
		head_nz  = (rem_b_s[N] != '0);
		tail_nz  = (rem_c_s[N] != '0);
		seg_end  = {8'b0, rem_a_s[N]} + {1'b0, len_s[N]};
		line_end = {8'b0, rem_b_s[N]} + {1'b0, len_s[N]};

		if (flags_s[N].zero_len || flags_s[N].one_len) begin
			tr_d = 2'd1;
		end else if (flags_s[N].fits_seg) begin
			tr_d = (seg_end > {8'b0, access_width_q}) ? 2'd2 : 2'd1;
		end else begin
			tr_d = (rem_a_s[N] != '0) ? 2'd3 : 2'd2;
		end

		if (flags_s[N].zero_len) begin
			full_d = '0;
			part_d = '0;
		end else if (flags_s[N].short_line) begin
			full_d = '0;
			part_d = (line_end > {8'b0, line_width_q}) ? 2'd2 : 2'd1;
		end else begin
			full_d = quo_c_s[N] - quo_b_s[N] - {15'b0, head_nz};
			part_d = {1'b0, head_nz} + {1'b0, tail_nz};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s10 <= valid_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tr_s10   <= tr_d;
			full_s10 <= full_d;
			part_s10 <= part_d;
		end
	end

	assign result.valid         = valid_s10;
	assign result.transactions  = tr_s10;
	assign result.full_lines    = full_s10;
	assign result.partial_lines = part_s10;

	`CASC_ASSERT_SAME(a_result_range, valid_s10,
		(tr_s10 != 2'd0) && (part_s10 != 2'd3), "result count out of range")
	`CASC_ASSERT_NEXT(a_transfer_enters, request.valid && request.ready,
		valid_s[0], "accepted transfer did not enter the pipeline")
	`CASC_ASSERT_NEXT(a_stall_holds, valid_s10 && !result.ready,
		$stable(valid_s[N]) && $stable(rem_a_s[N]) && $stable(quo_c_s[N]),
		"pipeline moved during an output stall")

endmodule
